// ===== rtl/rcpm_pkg.sv =====
// Shared package of the RC percent-to-channel mapper: field widths, register
// codes, the steering path code and the structs passed between the stages.
// No dependencies.
package rcpm_pkg;

  localparam int KIND_W    = 8;
  localparam int PCT_W     = 8;
  localparam int PULSE_W   = 12;
  localparam int CH_W      = 4;
  localparam int VAL_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 12;
  localparam int MODE_W    = 2;
  localparam int CHNUM_W   = 8;

  localparam int CH_VAL_MIN_DEF = 172;
  localparam int CH_VAL_MAX_DEF = 1811;

  localparam int PCT_LIMIT = 100;
  localparam int SERVO_OFFSET = 100;

  // Reset values of the registers.
  localparam logic [PULSE_W-1:0] SERVO_MIN_RST     = 12'd1000;
  localparam logic [PULSE_W-1:0] SERVO_MAX_RST     = 12'd2000;
  localparam logic [PULSE_W-1:0] SERVO_NEUTRAL_RST = 12'd1500;
  localparam logic [PULSE_W-1:0] ESC_MIN_RST       = 12'd1000;
  localparam logic [PULSE_W-1:0] ESC_MAX_RST       = 12'd2000;
  localparam logic [PULSE_W-1:0] ESC_NEUTRAL_RST   = 12'd1500;
  localparam logic [MODE_W-1:0]  MODE_FLAGS_RST    = 2'd3;
  localparam logic [CHNUM_W-1:0] CHANNEL_NUM_RST   = 8'd33;

  // Motor ids that always pick a path.
  localparam logic [KIND_W-1:0] KIND_THROTTLE = 8'd1;
  localparam logic [KIND_W-1:0] KIND_STEERING = 8'd2;

  // Pulse arithmetic: a factor up to 200 times a 13 bit difference.
  localparam int DIFF_W = PULSE_W + 1;
  localparam int FACT_W = 9;
  localparam int PROD_W = 21;
  localparam int MAG_W  = 20;

  // Division by 100 through a reciprocal, with one correction step.
  localparam int DIV_BY   = 100;
  localparam int RECIP_K  = 27;
  localparam int RECIP_M  = (2 ** RECIP_K) / DIV_BY;
  localparam int RECIP_MW = 21;
  localparam int RPROD_W  = MAG_W + RECIP_MW;
  localparam int Q_W      = 13;
  localparam int SQ_W     = Q_W + 1;
  localparam int SUM_W    = 15;

  // Channel scaling: numerator below 2**23, quotient below 2**11.
  localparam int CSPAN_W = VAL_W + 1;
  localparam int NUM_W   = DIFF_W + CSPAN_W;
  localparam int AMAG_W  = 23;
  localparam int QUO_W   = 11;
  localparam int V_W     = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERVO_MIN       = 3'd0,
    REG_SERVO_MAX       = 3'd1,
    REG_SERVO_NEUTRAL   = 3'd2,
    REG_ESC_MIN         = 3'd3,
    REG_ESC_MAX         = 3'd4,
    REG_ESC_NEUTRAL     = 3'd5,
    REG_MODE_FLAGS      = 3'd6,
    REG_CHANNEL_NUMBERS = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PATH_THROTTLE = 2'd0,
    PATH_SERVO    = 2'd1,
    PATH_MOTOR    = 2'd2
  } path_t;

  typedef struct packed {
    logic [PULSE_W-1:0] servo_min;
    logic [PULSE_W-1:0] servo_max;
    logic [PULSE_W-1:0] servo_neutral;
    logic [PULSE_W-1:0] esc_min;
    logic [PULSE_W-1:0] esc_max;
    logic [PULSE_W-1:0] esc_neutral;
    logic               reversible;
    logic               servo_mode;
    logic [CH_W-1:0]    thr_ch;
    logic [CH_W-1:0]    str_ch;
  } cfg_t;

  // Result of the pulse stages: pulse and span both relative to the minimum.
  typedef struct packed {
    logic signed [DIFF_W-1:0] off;
    logic signed [DIFF_W-1:0] span;
    logic [CH_W-1:0]          ch;
  } pulse_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [VAL_W-1:0] value;
  } res_t;

endpackage

// ===== rtl/rcpm_if.sv =====
// Valid/ready channel interfaces of the RC percent-to-channel mapper.
// Depends on rcpm_pkg.
interface rcpm_in_if;
  logic                                valid;
  logic                                ready;
  logic [rcpm_pkg::KIND_W-1:0]         kind;
  logic signed [rcpm_pkg::PCT_W-1:0]   percent;

  modport source(output valid, kind, percent, input ready);
  modport sink(input valid, kind, percent, output ready);
endinterface

interface rcpm_out_if;
  logic                          valid;
  logic                          ready;
  logic [rcpm_pkg::CH_W-1:0]     channel_index;
  logic [rcpm_pkg::VAL_W-1:0]    channel_value;

  modport source(output valid, channel_index, channel_value, input ready);
  modport sink(input valid, channel_index, channel_value, output ready);
endinterface

// ===== rtl/rcpm_cfg_regs.sv =====
// Configuration register file of the RC percent-to-channel mapper.
// Depends on rcpm_pkg.
module rcpm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rcpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcpm_pkg::CFG_W-1:0]       cfg_wdata,
  output rcpm_pkg::cfg_t                   cfg
);

  logic [rcpm_pkg::PULSE_W-1:0] servo_min_r, servo_max_r, servo_neutral_r;
  logic [rcpm_pkg::PULSE_W-1:0] esc_min_r, esc_max_r, esc_neutral_r;
  logic [rcpm_pkg::MODE_W-1:0]  mode_flags_r;
  logic [rcpm_pkg::CHNUM_W-1:0] channel_numbers_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_min_r       <= rcpm_pkg::SERVO_MIN_RST;
      servo_max_r       <= rcpm_pkg::SERVO_MAX_RST;
      servo_neutral_r   <= rcpm_pkg::SERVO_NEUTRAL_RST;
      esc_min_r         <= rcpm_pkg::ESC_MIN_RST;
      esc_max_r         <= rcpm_pkg::ESC_MAX_RST;
      esc_neutral_r     <= rcpm_pkg::ESC_NEUTRAL_RST;
      mode_flags_r      <= rcpm_pkg::MODE_FLAGS_RST;
      channel_numbers_r <= rcpm_pkg::CHANNEL_NUM_RST;
    end else if (cfg_we) begin
      case (rcpm_pkg::cfg_reg_t'(cfg_index))
        rcpm_pkg::REG_SERVO_MIN:       servo_min_r       <= cfg_wdata;
        rcpm_pkg::REG_SERVO_MAX:       servo_max_r       <= cfg_wdata;
        rcpm_pkg::REG_SERVO_NEUTRAL:   servo_neutral_r   <= cfg_wdata;
        rcpm_pkg::REG_ESC_MIN:         esc_min_r         <= cfg_wdata;
        rcpm_pkg::REG_ESC_MAX:         esc_max_r         <= cfg_wdata;
        rcpm_pkg::REG_ESC_NEUTRAL:     esc_neutral_r     <= cfg_wdata;
        rcpm_pkg::REG_MODE_FLAGS:      mode_flags_r      <= cfg_wdata[rcpm_pkg::MODE_W-1:0];
        rcpm_pkg::REG_CHANNEL_NUMBERS: channel_numbers_r <= cfg_wdata[rcpm_pkg::CHNUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.servo_min     = servo_min_r;
    cfg.servo_max     = servo_max_r;
    cfg.servo_neutral = servo_neutral_r;
    cfg.esc_min       = esc_min_r;
    cfg.esc_max       = esc_max_r;
    cfg.esc_neutral   = esc_neutral_r;
    cfg.reversible    = mode_flags_r[0];
    cfg.servo_mode    = mode_flags_r[1];
    cfg.thr_ch        = channel_numbers_r[rcpm_pkg::CH_W-1:0];
    cfg.str_ch        = channel_numbers_r[rcpm_pkg::CHNUM_W-1:rcpm_pkg::CH_W];
  end

endmodule

// ===== rtl/rcpm_pulse.sv =====
// Four-stage pulse pipeline: id decode and scaled difference, divide by 100 via a
// reciprocal, correction, servo halving and sign, then clamp. Depends on rcpm_pkg.
module rcpm_pulse (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rcpm_pkg::cfg_t                   cfg,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic [rcpm_pkg::KIND_W-1:0]      up_kind,
  input  logic signed [rcpm_pkg::PCT_W-1:0] up_percent,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output rcpm_pkg::pulse_t                 dn_data
);

  typedef struct packed {
    logic signed [rcpm_pkg::PROD_W-1:0] prod;
    logic [rcpm_pkg::PULSE_W-1:0]       base;
    logic [rcpm_pkg::PULSE_W-1:0]       lo;
    logic [rcpm_pkg::PULSE_W-1:0]       hi;
    logic [rcpm_pkg::CH_W-1:0]          ch;
    rcpm_pkg::path_t                    path;
  } s1_t;

  typedef struct packed {
    logic                               neg;
    logic [rcpm_pkg::MAG_W-1:0]         mag;
    logic [rcpm_pkg::Q_W-1:0]           q0;
    logic [rcpm_pkg::PULSE_W-1:0]       base;
    logic [rcpm_pkg::PULSE_W-1:0]       lo;
    logic [rcpm_pkg::PULSE_W-1:0]       hi;
    logic [rcpm_pkg::CH_W-1:0]          ch;
    rcpm_pkg::path_t                    path;
  } s2_t;

  typedef struct packed {
    logic signed [rcpm_pkg::SQ_W-1:0]   sq;
    logic [rcpm_pkg::PULSE_W-1:0]       base;
    logic [rcpm_pkg::PULSE_W-1:0]       lo;
    logic [rcpm_pkg::PULSE_W-1:0]       hi;
    logic [rcpm_pkg::CH_W-1:0]          ch;
    rcpm_pkg::path_t                    path;
  } s3_t;

  localparam logic signed [rcpm_pkg::PCT_W-1:0] PCT_HI = rcpm_pkg::PCT_W'(rcpm_pkg::PCT_LIMIT);
  localparam logic signed [rcpm_pkg::PCT_W-1:0] PCT_LO = rcpm_pkg::PCT_W'(-rcpm_pkg::PCT_LIMIT);

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  rcpm_pkg::pulse_t s4_r, s4_nxt;
  logic match_thr, match_str;

  // A stage takes new data when it is empty or its content moves on.
  assign en4 = !v4_r || dn_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign up_ready = en1;

  // Stage 1: decode the id, clamp the percent, form factor times difference.
  always_comb begin
    logic signed [rcpm_pkg::PCT_W-1:0]   pc;
    logic signed [rcpm_pkg::FACT_W-1:0]  fact;
    logic signed [rcpm_pkg::DIFF_W-1:0]  diff;
    logic signed [rcpm_pkg::DIFF_W-1:0]  lo_s, hi_s, mid_s;
    logic [rcpm_pkg::PULSE_W-1:0]        mid;
    logic                                rev;
    logic signed [rcpm_pkg::FACT_W+rcpm_pkg::DIFF_W-1:0] full;

    if (up_percent > PCT_HI) begin
      pc = PCT_HI;
    end else if (up_percent < PCT_LO) begin
      pc = PCT_LO;
    end else begin
      pc = up_percent;
    end

    match_thr = (up_kind == rcpm_pkg::KIND_THROTTLE) ||
                (up_kind == rcpm_pkg::KIND_W'(cfg.thr_ch));
    match_str = (up_kind == rcpm_pkg::KIND_STEERING) ||
                (up_kind == rcpm_pkg::KIND_W'(cfg.str_ch));

    if (match_thr) begin
      s1_nxt.path = rcpm_pkg::PATH_THROTTLE;
      s1_nxt.lo   = cfg.esc_min;
      s1_nxt.hi   = cfg.esc_max;
      mid         = cfg.esc_neutral;
      rev         = cfg.reversible;
      s1_nxt.ch   = cfg.thr_ch;
    end else begin
      s1_nxt.path = cfg.servo_mode ? rcpm_pkg::PATH_SERVO : rcpm_pkg::PATH_MOTOR;
      s1_nxt.lo   = cfg.servo_min;
      s1_nxt.hi   = cfg.servo_max;
      mid         = cfg.servo_neutral;
      rev         = 1'b1;
      s1_nxt.ch   = cfg.str_ch;
    end

    lo_s  = $signed({1'b0, s1_nxt.lo});
    hi_s  = $signed({1'b0, s1_nxt.hi});
    mid_s = $signed({1'b0, mid});

    if (s1_nxt.path == rcpm_pkg::PATH_SERVO) begin
      fact        = rcpm_pkg::FACT_W'(pc) + rcpm_pkg::FACT_W'(rcpm_pkg::SERVO_OFFSET);
      diff        = hi_s - lo_s;
      s1_nxt.base = s1_nxt.lo;
    end else begin
      s1_nxt.base = mid;
      if (pc >= 0) begin
        fact = rcpm_pkg::FACT_W'(pc);
        diff = hi_s - mid_s;
      end else begin
        // Without reverse a negative command holds the pulse at neutral.
        fact = rev ? rcpm_pkg::FACT_W'(pc) : '0;
        diff = mid_s - lo_s;
      end
    end

    full        = fact * diff;
    s1_nxt.prod = full[rcpm_pkg::PROD_W-1:0];
  end

  // Stage 2: magnitude times the reciprocal of 100; the estimate may be one low.
  always_comb begin
    logic [rcpm_pkg::PROD_W-1:0]  absv;
    logic [rcpm_pkg::RPROD_W-1:0] rprod;

    s2_nxt.neg  = s1_r.prod[rcpm_pkg::PROD_W-1];
    absv        = s2_nxt.neg ? rcpm_pkg::PROD_W'(-s1_r.prod) : rcpm_pkg::PROD_W'(s1_r.prod);
    s2_nxt.mag  = absv[rcpm_pkg::MAG_W-1:0];
    rprod       = rcpm_pkg::RPROD_W'(s2_nxt.mag) * rcpm_pkg::RPROD_W'(rcpm_pkg::RECIP_M);
    s2_nxt.q0   = rprod[rcpm_pkg::RECIP_K+rcpm_pkg::Q_W-1:rcpm_pkg::RECIP_K];
    s2_nxt.base = s1_r.base;
    s2_nxt.lo   = s1_r.lo;
    s2_nxt.hi   = s1_r.hi;
    s2_nxt.ch   = s1_r.ch;
    s2_nxt.path = s1_r.path;
  end

  // Stage 3: correct the quotient, halve it for the servo path, restore sign.
  always_comb begin
    logic [rcpm_pkg::MAG_W-1:0] rem;
    logic [rcpm_pkg::Q_W-1:0]   q;

    rem = s2_r.mag - rcpm_pkg::MAG_W'(rcpm_pkg::MAG_W'(s2_r.q0) *
                                      rcpm_pkg::MAG_W'(rcpm_pkg::DIV_BY));
    q   = s2_r.q0 + rcpm_pkg::Q_W'(rem >= rcpm_pkg::MAG_W'(rcpm_pkg::DIV_BY));
    if (s2_r.path == rcpm_pkg::PATH_SERVO) begin
      q = q >> 1;
    end
    s3_nxt.sq   = s2_r.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    s3_nxt.base = s2_r.base;
    s3_nxt.lo   = s2_r.lo;
    s3_nxt.hi   = s2_r.hi;
    s3_nxt.ch   = s2_r.ch;
    s3_nxt.path = s2_r.path;
  end

  // Stage 4: add to the base; throttle clamps low first, motor high first, servo not.
  always_comb begin
    logic signed [rcpm_pkg::SUM_W-1:0] pulse, t, lo_s, hi_s;

    lo_s  = rcpm_pkg::SUM_W'($signed({1'b0, s3_r.lo}));
    hi_s  = rcpm_pkg::SUM_W'($signed({1'b0, s3_r.hi}));
    pulse = rcpm_pkg::SUM_W'($signed({1'b0, s3_r.base})) + rcpm_pkg::SUM_W'(s3_r.sq);
    t     = pulse;
    case (s3_r.path)
      rcpm_pkg::PATH_THROTTLE: begin
        if (t < lo_s) t = lo_s;
        if (t > hi_s) t = hi_s;
      end
      rcpm_pkg::PATH_MOTOR: begin
        if (t > hi_s) t = hi_s;
        if (t < lo_s) t = lo_s;
      end
      default: ;
    endcase
    s4_nxt.off  = rcpm_pkg::DIFF_W'(t - lo_s);
    s4_nxt.span = rcpm_pkg::DIFF_W'(hi_s - lo_s);
    s4_nxt.ch   = s3_r.ch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      // An id that matches neither path is taken and dropped here.
      if (en1) v1_r <= up_valid && (match_thr || match_str);
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
    if (en3) s3_r <= s3_nxt;
    if (en4) s4_r <= s4_nxt;
  end

  assign dn_valid = v4_r;
  assign dn_data  = s4_r;

endmodule

// ===== rtl/rcpm_scale.sv =====
// Channel scaling pipeline: constant multiply, one restoring division stage
// per quotient bit, then offset and saturation into the output register.
// Depends on rcpm_pkg.
module rcpm_scale #(
  parameter int CH_VAL_MIN = rcpm_pkg::CH_VAL_MIN_DEF,
  parameter int CH_VAL_MAX = rcpm_pkg::CH_VAL_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  rcpm_pkg::pulse_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output rcpm_pkg::res_t    dn_data
);

  localparam int QW = rcpm_pkg::QUO_W;
  localparam logic signed [rcpm_pkg::CSPAN_W-1:0] CSPAN =
    rcpm_pkg::CSPAN_W'(CH_VAL_MAX - CH_VAL_MIN);
  localparam logic signed [rcpm_pkg::V_W-1:0] CMIN = rcpm_pkg::V_W'(CH_VAL_MIN);
  localparam logic signed [rcpm_pkg::V_W-1:0] VMAX = rcpm_pkg::V_W'((2 ** rcpm_pkg::VAL_W) - 1);

  typedef struct packed {
    logic                            neg;
    logic                            zero;
    logic [rcpm_pkg::AMAG_W-1:0]     rem;
    logic [rcpm_pkg::PULSE_W-1:0]    dmag;
    logic [QW-1:0]                   quo;
    logic [rcpm_pkg::CH_W-1:0]       ch;
  } dv_t;

  function automatic dv_t div_step(dv_t d, int bitpos);
    dv_t r;
    logic [rcpm_pkg::AMAG_W-1:0] sh;
    r  = d;
    sh = rcpm_pkg::AMAG_W'(d.dmag) << bitpos;
    if (d.rem >= sh) begin
      r.rem         = d.rem - sh;
      r.quo[bitpos] = 1'b1;
    end
    return r;
  endfunction

  logic          sv_r [0:QW];
  dv_t           sd_r [0:QW];
  logic [0:QW+1] en;
  dv_t           s0_nxt;
  logic          ov_r;
  rcpm_pkg::res_t od_r, od_nxt;

  assign en[QW+1]  = !ov_r || dn_ready;
  assign up_ready  = en[0];

  // Stage 0: numerator (pulse offset times channel span) and divisor magnitude.
  always_comb begin
    logic signed [rcpm_pkg::NUM_W-1:0] num;
    logic [rcpm_pkg::NUM_W-1:0]        nabs;
    logic [rcpm_pkg::DIFF_W-1:0]       dabs;

    num  = rcpm_pkg::NUM_W'(up_data.off) * rcpm_pkg::NUM_W'(CSPAN);
    nabs = num[rcpm_pkg::NUM_W-1] ? rcpm_pkg::NUM_W'(-num) : rcpm_pkg::NUM_W'(num);
    dabs = up_data.span[rcpm_pkg::DIFF_W-1] ? rcpm_pkg::DIFF_W'(-up_data.span)
                                           : rcpm_pkg::DIFF_W'(up_data.span);
    s0_nxt.neg  = num[rcpm_pkg::NUM_W-1] ^ up_data.span[rcpm_pkg::DIFF_W-1];
    s0_nxt.zero = (up_data.span == '0);
    s0_nxt.rem  = nabs[rcpm_pkg::AMAG_W-1:0];
    s0_nxt.dmag = dabs[rcpm_pkg::PULSE_W-1:0];
    s0_nxt.quo  = '0;
    s0_nxt.ch   = up_data.ch;
  end

  assign en[0] = !sv_r[0] || en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en[0]) begin
      sv_r[0] <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) sd_r[0] <= s0_nxt;
  end

  // Stage k settles quotient bit QW-k; the quotient never reaches 2**QW.
  for (genvar k = 1; k <= QW; k++) begin : g_div
    assign en[k] = !sv_r[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else if (en[k]) begin
        sv_r[k] <= sv_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) sd_r[k] <= div_step(sd_r[k-1], QW - k);
    end
  end

  // Final stage: signed quotient plus channel minimum, saturated; index less one.
  always_comb begin
    logic signed [rcpm_pkg::V_W-1:0] q, v;

    q = sd_r[QW].neg ? -rcpm_pkg::V_W'(sd_r[QW].quo) : rcpm_pkg::V_W'(sd_r[QW].quo);
    v = sd_r[QW].zero ? CMIN : CMIN + q;
    if (v < 0) begin
      v = '0;
    end else if (v > VMAX) begin
      v = VMAX;
    end
    od_nxt.value = v[rcpm_pkg::VAL_W-1:0];
    od_nxt.ch    = sd_r[QW].ch - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en[QW+1]) begin
      ov_r <= sv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en[QW+1]) od_r <= od_nxt;
  end

  assign dn_valid = ov_r;
  assign dn_data  = od_r;

endmodule

// ===== rtl/rc_percent_to_channel_mapper.sv =====
// Top level of the RC percent-to-channel mapper: configuration registers,
// pulse pipeline and channel scaling pipeline. Depends on rcpm_pkg, rcpm_if.
//
// A transaction carries a motor id and a signed percent; it yields one
// channel index and value, or nothing when the id matches neither the
// throttle nor the steering id or channel number. The block is a 17-stage
// pipeline: four stages form the pulse width (division by 100 through a
// reciprocal multiply), one forms the scaled numerator, eleven run a
// restoring divide by the pulse span one quotient bit each, and the last is
// the output register. It takes one transaction per cycle when the output is
// not stalled; a stall backs up through the stages, each of which still
// accepts data while it is empty. Write the configuration registers only
// while the pipeline is empty.
module rc_percent_to_channel_mapper #(
  parameter int CH_VAL_MIN = rcpm_pkg::CH_VAL_MIN_DEF,
  parameter int CH_VAL_MAX = rcpm_pkg::CH_VAL_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rcpm_in_if.sink                          in_ch,
  rcpm_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [rcpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcpm_pkg::CFG_W-1:0]       cfg_wdata
);

  rcpm_pkg::cfg_t   cfg;
  logic             pl_valid;
  logic             pl_ready;
  rcpm_pkg::pulse_t pl_data;
  rcpm_pkg::res_t   res;

  rcpm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rcpm_pulse u_pulse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .up_valid   (in_ch.valid),
    .up_ready   (in_ch.ready),
    .up_kind    (in_ch.kind),
    .up_percent (in_ch.percent),
    .dn_valid   (pl_valid),
    .dn_ready   (pl_ready),
    .dn_data    (pl_data)
  );

  rcpm_scale #(
    .CH_VAL_MIN (CH_VAL_MIN),
    .CH_VAL_MAX (CH_VAL_MAX)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (pl_valid),
    .up_ready (pl_ready),
    .up_data  (pl_data),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (res)
  );

  assign out_ch.channel_index = res.ch;
  assign out_ch.channel_value = res.value;

endmodule
